// ===== sv/spml_pkg.sv =====
// Shared types, constants and update-rule tables for the spectral PML field update.
`default_nettype none
package spml_pkg;

   localparam int NUM_COMP = 12;
   localparam int NUM_COEF = 5;

   // Kind of a load word after decoding.
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_COMP = 2'd1;
   localparam logic [1:0] KIND_COEF = 2'd2;

   localparam logic [3:0] LAST_COMP = 4'd11;

   typedef struct packed {
      logic [1:0]         kind;
      logic [3:0]         idx;
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic               last;
   } cmd_type;

   typedef struct packed {
      logic [3:0]         slot;
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic               last;
      logic               sat;
   } rsp_type;

   // Saturate a wide signed value to 32 bits; the top bit flags clipping.
   function automatic logic [32:0] sat32(input logic signed [65:0] v);
      logic [32:0] r;
      if (v > 66'sd2147483647) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -66'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   // True where the crossing term is subtracted on the imaginary part.
   function automatic logic rule_neg(input logic [3:0] s);
      logic r;
      case (s)
         4'd1, 4'd2, 4'd5, 4'd6, 4'd9, 4'd10: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // Wave vector component: 0 kx, 1 ky, 2 kz.
   function automatic logic [1:0] rule_kidx(input logic [3:0] s);
      logic [1:0] r;
      case (s)
         4'd2, 4'd4, 4'd8, 4'd10: r = 2'd0;
         4'd1, 4'd3, 4'd7, 4'd9: r = 2'd2;
         default: r = 2'd1;
      endcase
      return r;
   endfunction

   // Crossing total: 0 Ex, 1 Ey, 2 Ez, 3 Bx, 4 By, 5 Bz.
   function automatic logic [2:0] rule_tidx(input logic [3:0] s);
      logic [2:0] r;
      case (s)
         4'd0, 4'd2: r = 3'd5;
         4'd1, 4'd4: r = 3'd4;
         4'd3, 4'd5: r = 3'd3;
         4'd6, 4'd8: r = 3'd2;
         4'd7, 4'd10: r = 3'd1;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/spml_fifo.sv =====
// Small first-in first-out queue of words held in flip-flops.
`default_nettype none
module spml_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = data_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         data_ff[wptr_ff] <= wdata;
      end
   end
endmodule
`default_nettype wire

// ===== sv/spml_front.sv =====
// Front end: classifies load words and queues them for the update engine.
`default_nettype none
module spml_front import spml_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [4:0]         req_slot,
   input  wire logic signed [31:0] req_value_re,
   input  wire logic signed [31:0] req_value_im,
   input  wire logic               req_last,
   output cmd_type                 cmd,
   output logic                    cmd_valid,
   input  wire logic               cmd_pop
);
   cmd_type           dec;
   logic [$bits(cmd_type)-1:0] q_rdata;
   logic              q_empty;

   always_comb begin
      dec.re   = req_value_re;
      dec.im   = req_value_im;
      dec.last = req_last;
      if (req_slot < 5'(NUM_COMP)) begin
         dec.kind = KIND_COMP;
         dec.idx  = req_slot[3:0];
      end else if (req_slot < 5'(NUM_COMP + NUM_COEF)) begin
         dec.kind = KIND_COEF;
         dec.idx  = 4'(req_slot - 5'(NUM_COMP));
      end else begin
         dec.kind = KIND_NONE;
         dec.idx  = '0;
      end
   end

   spml_fifo #(.WIDTH($bits(cmd_type)), .DEPTH(4)) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (dec),
      .full  (req_full),
      .pop   (cmd_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign cmd       = cmd_type'(q_rdata);
   assign cmd_valid = !q_empty;
endmodule
`default_nettype wire

// ===== sv/spml_back.sv =====
// Back end: component store, coefficients and the sequenced field update.
`default_nettype none
module spml_back import spml_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   input  wire logic        cmd_valid,
   output logic             cmd_pop,
   input  wire logic [31:0] light_speed_squared,
   output rsp_type          rsp,
   output logic             rsp_push,
   input  wire logic        rsp_full,
   output logic             busy
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_TOT  = 3'd1;
   localparam logic [2:0] ST_SK   = 3'd2;
   localparam logic [2:0] ST_SKS  = 3'd3;
   localparam logic [2:0] ST_C2   = 3'd4;
   localparam logic [2:0] ST_C2S  = 3'd5;
   localparam logic [2:0] ST_MUL  = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [63:0]        comp_mem [NUM_COMP];
   logic [63:0]        rdata_ff;
   logic [3:0]         raddr, waddr, tot_idx;
   logic [63:0]        wdata;
   logic               mem_we;
   logic signed [31:0] coef_ff [NUM_COEF];
   logic signed [31:0] tot_re_ff [6];
   logic signed [31:0] tot_im_ff [6];
   logic               tsat_ff [6];
   logic signed [31:0] hold_re_ff, hold_im_ff;
   logic signed [64:0] prod_ff;
   logic signed [31:0] sk_ff;
   logic signed [63:0] p_ff, q_ff, cr_ff, ci_ff;
   logic               sat_ff;
   logic [2:0]         tidx;
   logic [1:0]         kidx;
   logic signed [31:0] kval, cur_re, cur_im;
   logic [32:0]        sk_sat, tre_sat, tim_sat, yre_sat, yim_sat;
   logic signed [63:0] a_re, a_im, b_p, b_q;
   logic signed [65:0] sum_re, sum_im;

   assign tidx    = rule_tidx(cnt_ff);
   assign kidx    = rule_kidx(cnt_ff);
   assign kval    = coef_ff[3'(kidx) + 3'd2];
   assign raddr   = (cnt_ff < 4'(NUM_COMP)) ? cnt_ff : '0;
   assign cur_re  = rdata_ff[63:32];
   assign cur_im  = rdata_ff[31:0];
   assign tot_idx = cnt_ff - 1'b1;
   assign busy    = (state_ff != ST_IDLE);
   assign cmd_pop = (state_ff == ST_IDLE) && cmd_valid;

   assign sk_sat  = sat32(66'(prod_ff >>> FRAC_BITS));
   assign tre_sat = sat32(66'(hold_re_ff) + 66'(cur_re));
   assign tim_sat = sat32(66'(hold_im_ff) + 66'(cur_im));

   assign a_re = cr_ff >>> FRAC_BITS;
   assign a_im = ci_ff >>> FRAC_BITS;
   assign b_p  = p_ff >>> FRAC_BITS;
   assign b_q  = q_ff >>> FRAC_BITS;
   assign sum_re = rule_neg(cnt_ff) ? 66'(a_re) + 66'(b_q) : 66'(a_re) - 66'(b_q);
   assign sum_im = rule_neg(cnt_ff) ? 66'(a_im) - 66'(b_p) : 66'(a_im) + 66'(b_p);
   assign yre_sat = sat32(sum_re);
   assign yim_sat = sat32(sum_im);

   assign rsp.slot = cnt_ff;
   assign rsp.re   = yre_sat[31:0];
   assign rsp.im   = yim_sat[31:0];
   assign rsp.last = (cnt_ff == LAST_COMP);
   assign rsp.sat  = sat_ff | yre_sat[32] | yim_sat[32];
   assign rsp_push = (state_ff == ST_OUT) && !rsp_full;

   always_comb begin
      mem_we = 1'b0;
      waddr  = cmd.idx;
      wdata  = {cmd.re, cmd.im};
      if (cmd_pop && cmd.kind == KIND_COMP) begin
         mem_we = 1'b1;
      end else if (rsp_push) begin
         mem_we = 1'b1;
         waddr  = cnt_ff;
         wdata  = {yre_sat[31:0], yim_sat[31:0]};
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_pop && cmd.last) begin
               state_in = ST_TOT;
               cnt_in   = '0;
            end
         end
         ST_TOT: begin
            if (cnt_ff == 4'(NUM_COMP)) begin
               state_in = ST_SK;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SK:  state_in = ST_SKS;
         ST_SKS: state_in = (cnt_ff < 4'(NUM_COMP / 2)) ? ST_C2 : ST_MUL;
         ST_C2:  state_in = ST_C2S;
         ST_C2S: state_in = ST_MUL;
         ST_MUL: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_push) begin
               if (cnt_ff == LAST_COMP) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SK;
                  cnt_in   = cnt_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Component store with one write and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         comp_mem[waddr] <= wdata;
      end
      rdata_ff <= comp_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && cmd.kind == KIND_COEF) begin
         coef_ff[3'(cmd.idx)] <= cmd.re;
      end
      // Totals: even entries are held, odd entries close the pair.
      if (state_ff == ST_TOT && cnt_ff != '0) begin
         if (!tot_idx[0]) begin
            hold_re_ff <= cur_re;
            hold_im_ff <= cur_im;
         end else begin
            tot_re_ff[tot_idx[3:1]] <= tre_sat[31:0];
            tot_im_ff[tot_idx[3:1]] <= tim_sat[31:0];
            tsat_ff[tot_idx[3:1]]   <= tre_sat[32] | tim_sat[32];
         end
      end
      case (state_ff)
         ST_SK: begin
            prod_ff <= 65'(coef_ff[1] * kval);
            sat_ff  <= tsat_ff[tidx];
         end
         ST_SKS, ST_C2S: begin
            sk_ff  <= sk_sat[31:0];
            sat_ff <= sat_ff | sk_sat[32];
         end
         ST_C2: begin
            prod_ff <= sk_ff * $signed({1'b0, light_speed_squared});
         end
         ST_MUL: begin
            cr_ff <= coef_ff[0] * cur_re;
            ci_ff <= coef_ff[0] * cur_im;
            p_ff  <= sk_ff * tot_re_ff[tidx];
            q_ff  <= sk_ff * tot_im_ff[tidx];
         end
         default: begin
         end
      endcase
   end
endmodule
`default_nettype wire

// ===== sv/spectral_pml_field_update.sv =====
// Top level of the spectral PML split-field update engine.
// Load words enter through req_push/req_full: slots 0..11 carry the split
// E and B components, slots 12..16 the coefficients C, S_ck, kx, ky, kz.
// A word with req_last is stored if in range and starts the point's update.
// Results leave through rsp_empty/rsp_pop as twelve words in slot order, the
// twelfth marked by rsp_out_last; the new values are also written back.
// Loads are taken one per cycle into a four-word queue while it has room. An
// update forms the pair totals through the component store's read port, then
// steps each component through the shared multiply sequencer (E: SK, SKS, C2,
// C2S, MUL, OUT; B skips C2 and C2S); loads queue meanwhile.
// The result queue holds four words; when the receiver stalls, the
// sequencer waits on it and the load queue fills and raises req_full.
// The user writes csr_light_speed_squared only while the block is idle;
// the block does not enforce it. Reset empties both queues, returns the
// sequencer to idle and sets c squared to one; stores keep what they held.
`default_nettype none
module spectral_pml_field_update import spml_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [4:0]         req_slot,
   input  wire logic signed [31:0] req_value_re,
   input  wire logic signed [31:0] req_value_im,
   input  wire logic               req_last,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [3:0]              rsp_out_slot,
   output logic signed [31:0]      rsp_out_re,
   output logic signed [31:0]      rsp_out_im,
   output logic                    rsp_out_last,
   output logic                    rsp_saturated,
   input  wire logic               csr_write,
   input  wire logic [31:0]        csr_light_speed_squared
);
   cmd_type     cmd;
   logic        cmd_valid, cmd_pop, busy;
   rsp_type     rsp_in, rsp_head;
   logic        rsp_push, rsp_full;
   logic [$bits(rsp_type)-1:0] rsp_rdata;
   logic [31:0] c2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_ff <= 32'd65536;
      end else if (csr_write) begin
         c2_ff <= csr_light_speed_squared;
      end
   end

   spml_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_slot     (req_slot),
      .req_value_re (req_value_re),
      .req_value_im (req_value_im),
      .req_last     (req_last),
      .cmd          (cmd),
      .cmd_valid    (cmd_valid),
      .cmd_pop      (cmd_pop)
   );

   spml_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .cmd_valid           (cmd_valid),
      .cmd_pop             (cmd_pop),
      .light_speed_squared (c2_ff),
      .rsp                 (rsp_in),
      .rsp_push            (rsp_push),
      .rsp_full            (rsp_full),
      .busy                (busy)
   );

   spml_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(4)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_in),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_rdata),
      .empty (rsp_empty)
   );

   assign rsp_head      = rsp_type'(rsp_rdata);
   assign rsp_out_slot  = rsp_head.slot;
   assign rsp_out_re    = rsp_head.re;
   assign rsp_out_im    = rsp_head.im;
   assign rsp_out_last  = rsp_head.last;
   assign rsp_saturated = rsp_head.sat;

   a_no_pop_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !cmd_pop) else $error("load word taken during an update");

   a_push_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> busy && !rsp_full) else $error("result pushed outside an update");

   a_last_on_slot11: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_out_last) |-> rsp_out_slot == LAST_COMP)
      else $error("last flag on wrong slot");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_in.last) |=> !busy) else $error("sequencer ran past the last slot");
endmodule
`default_nettype wire

// ===== tb/tb_spectral_pml_field_update.sv =====
// Self-checking testbench for the spectral PML split-field update engine.
module tb_spectral_pml_field_update;
   import spml_pkg::*;

   localparam int FRAC = 16;
   localparam logic [4:0] SLOT_C   = 5'd12;
   localparam logic [4:0] SLOT_SCK = 5'd13;
   localparam logic [4:0] SLOT_KY  = 5'd15;
   localparam logic [31:0] ONE_Q   = 32'h0001_0000;
   localparam int IDLE_WAIT = 120;

   logic clock, reset;
   logic req_push, req_full, req_last;
   logic [4:0] req_slot;
   logic signed [31:0] req_value_re, req_value_im;
   logic rsp_empty, rsp_pop;
   logic [3:0] rsp_out_slot;
   logic signed [31:0] rsp_out_re, rsp_out_im;
   logic rsp_out_last, rsp_saturated;
   logic csr_write;
   logic [31:0] csr_light_speed_squared;

   spectral_pml_field_update DUT (.*);

   typedef struct {
      logic [4:0] slot;
      logic [31:0] re;
      logic [31:0] im;
      logic last;
   } load_word;

   // Predictor state.
   logic signed [31:0] comp_re [NUM_COMP];
   logic signed [31:0] comp_im [NUM_COMP];
   logic signed [31:0] coef [NUM_COEF];
   logic [31:0] c_sq;

   rsp_type expected_words[$];
   int mismatches;
   bit quiet_tail;
   bit rx_quiet;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic signed [65:0] floor_q(input logic signed [65:0] v);
      return v >>> FRAC;
   endfunction

   // Saturate to 32 signed bits and raise the flag when clipped.
   function automatic logic signed [65:0] clip(input logic signed [65:0] v,
                                              inout bit flag);
      if (v > 66'sd2147483647) begin
         flag = 1;
         return 66'sd2147483647;
      end
      if (v < -66'sd2147483648) begin
         flag = 1;
         return -66'sd2147483648;
      end
      return v;
   endfunction

   task automatic predict_load(input load_word w);
      logic signed [65:0] tre [6], tim [6];
      bit tsat [6];
      logic signed [31:0] nre [NUM_COMP], nim [NUM_COMP];
      logic signed [65:0] sk, p, q, yre, yim;
      bit sat, neg, is_e;
      logic [1:0] kx;
      logic [2:0] ti;
      rsp_type r;
      if (w.slot < NUM_COMP) begin
         comp_re[w.slot[3:0]] = w.re;
         comp_im[w.slot[3:0]] = w.im;
      end else if (w.slot < NUM_COMP + NUM_COEF) begin
         coef[w.slot - NUM_COMP] = w.re;
      end
      if (!w.last) return;
      for (int i = 0; i < 6; i++) begin
         tsat[i] = 0;
         tre[i] = clip(66'(comp_re[2*i]) + 66'(comp_re[2*i+1]), tsat[i]);
         tim[i] = clip(66'(comp_im[2*i]) + 66'(comp_im[2*i+1]), tsat[i]);
      end
      for (int i = 0; i < NUM_COMP; i++) begin
         // Independent rule table: E rows first, then B rows.
         case (i)
            0:  begin neg = 0; kx = 1; ti = 5; end
            1:  begin neg = 1; kx = 2; ti = 4; end
            2:  begin neg = 1; kx = 0; ti = 5; end
            3:  begin neg = 0; kx = 2; ti = 3; end
            4:  begin neg = 0; kx = 0; ti = 4; end
            5:  begin neg = 1; kx = 1; ti = 3; end
            6:  begin neg = 1; kx = 1; ti = 2; end
            7:  begin neg = 0; kx = 2; ti = 1; end
            8:  begin neg = 0; kx = 0; ti = 2; end
            9:  begin neg = 1; kx = 2; ti = 0; end
            10: begin neg = 1; kx = 0; ti = 1; end
            default: begin neg = 0; kx = 1; ti = 0; end
         endcase
         is_e = i < 6;
         sat = tsat[ti];
         sk = clip(floor_q(66'(coef[1]) * 66'(coef[2 + kx])), sat);
         if (is_e) sk = clip(floor_q(sk * $signed({34'd0, c_sq})), sat);
         p = floor_q(sk * tre[ti]);
         q = floor_q(sk * tim[ti]);
         if (!neg) begin
            yre = floor_q(66'(coef[0]) * 66'(comp_re[i])) - q;
            yim = floor_q(66'(coef[0]) * 66'(comp_im[i])) + p;
         end else begin
            yre = floor_q(66'(coef[0]) * 66'(comp_re[i])) + q;
            yim = floor_q(66'(coef[0]) * 66'(comp_im[i])) - p;
         end
         yre = clip(yre, sat);
         yim = clip(yim, sat);
         nre[i] = yre[31:0];
         nim[i] = yim[31:0];
         r.slot = i[3:0];
         r.re = nre[i];
         r.im = nim[i];
         r.last = (i == NUM_COMP - 1);
         r.sat = sat;
         expected_words.push_back(r);
      end
      comp_re = nre;
      comp_im = nim;
   endtask

   task automatic send_word(input load_word w);
      // Random sender idle bursts, none in the quiet tail.
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_slot <= w.slot;
      req_value_re <= w.re;
      req_value_im <= w.im;
      req_last <= w.last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_load(w);
   endtask

   task automatic drain_and_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic write_c_sq(input logic [31:0] v);
      csr_write <= 1'b1;
      csr_light_speed_squared <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      c_sq = v;
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         default: return $urandom;
      endcase
   endfunction

   // A full point: every component and coefficient, random order, last at the end.
   task automatic send_point(input bit two_d);
      int order [17];
      load_word w;
      for (int i = 0; i < 17; i++) order[i] = i;
      order.shuffle();
      for (int i = 0; i < 17; i++) begin
         w.slot = 5'(order[i]);
         w.re = rand_value();
         w.im = rand_value();
         if (w.slot == SLOT_KY && two_d) w.re = 32'h0;
         w.last = (i == 16);
         send_word(w);
      end
   endtask

   // Receiver with random stall bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word slot %0d", rsp_out_slot);
            end else begin
               rsp_type e;
               e = expected_words.pop_front();
               if (e.slot !== rsp_out_slot || e.re !== rsp_out_re || e.im !== rsp_out_im
                   || e.last !== rsp_out_last || e.sat !== rsp_saturated) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp slot %0d re %h im %h last %b sat %b, got %0d %h %h %b %b",
                        e.slot, e.re, e.im, e.last, e.sat, rsp_out_slot, rsp_out_re,
                        rsp_out_im, rsp_out_last, rsp_saturated);
               end
            end
         end
         if (quiet_tail) rsp_pop <= 1'b1;
         else if (rx_quiet) rsp_pop <= 1'b0;
         else rsp_pop <= ($urandom_range(0, 7) != 0);
      end
   end

   initial begin
      int stall;
      forever begin
         @(posedge clock);
         if (!quiet_tail && $urandom_range(0, 30) == 0) begin
            rx_quiet = 1;
            stall = $urandom_range(1, 19);
            repeat (stall) @(posedge clock);
            rx_quiet = 0;
         end
      end
   end

   load_word directed [$];

   initial begin
      load_word w;
      mismatches = 0;
      quiet_tail = 0;
      rx_quiet = 0;
      reset = 1'b1;
      req_push = 1'b0;
      req_slot = '0;
      req_value_re = '0;
      req_value_im = '0;
      req_last = 1'b0;
      csr_write = 1'b0;
      csr_light_speed_squared = '0;
      c_sq = ONE_Q;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: all zero but C one gives zero results; then identity C, extremes.
      for (int s = 0; s < 17; s++)
         directed.push_back('{s[4:0], 32'h0, 32'h0, 1'b0});
      directed.push_back('{SLOT_C, ONE_Q, 32'h0, 1'b1});
      directed.push_back('{5'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0});
      directed.push_back('{5'd1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0});
      directed.push_back('{SLOT_SCK, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0});
      directed.push_back('{SLOT_KY, 32'h8000_0000, 32'h1234_5678, 1'b0});
      directed.push_back('{5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
      directed.push_back('{5'd17, 32'h0, 32'h0, 1'b1});
      foreach (directed[i]) begin
         send_word(directed[i]);
         // After the first update with C one and all else zero, every word is zero.
         if (i == 17) begin
            foreach (expected_words[j])
               if (expected_words[j].re !== 0 || expected_words[j].im !== 0) begin
                  mismatches++;
                  $display("zero point predicted nonzero");
               end
         end
      end
      drain_and_idle();

      // Random phases over several c squared settings, extremes included.
      for (int k = 0; k < 4; k++) begin
         case (k)
            0: write_c_sq(32'h0);
            1: write_c_sq(32'hFFFF_FFFF);
            2: write_c_sq($urandom);
            default: write_c_sq(ONE_Q);
         endcase
         for (int n = 0; n < 4; n++) begin
            send_point($urandom_range(0, 2) == 0);
            // Partial refresh and noise words mixed in.
            for (int m = 0; m < $urandom_range(0, 4); m++) begin
               w.slot = 5'($urandom_range(0, 31));
               w.re = rand_value();
               w.im = rand_value();
               w.last = ($urandom_range(0, 3) == 0);
               send_word(w);
            end
         end
         drain_and_idle();
      end

      quiet_tail = 1;
      for (int n = 0; n < 2; n++) send_point(0);
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
